>>> design/kct_pkg.sv
// ----------------------------------------------------------------------------
// kct_pkg: shared types and constants of the keyed counter table
// Holds the key and count types, the action and status codes, and the key
// clean-up function used when a word is taken in.
// ----------------------------------------------------------------------------
package kct_pkg;

  localparam int KEY_BYTES = 31;
  localparam int KEY_W     = KEY_BYTES * 8;
  localparam int CNT_W     = 31;
  localparam int ACT_W     = 3;
  localparam int ST_W      = 2;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [ACT_W-1:0] act_t;
  typedef logic [ST_W-1:0]  st_t;

  localparam cnt_t COUNT_MAX = {CNT_W{1'b1}};

  localparam act_t ACT_BUMP    = 3'd0;
  localparam act_t ACT_QUERY   = 3'd1;
  localparam act_t ACT_CLEAR   = 3'd2;
  localparam act_t ACT_SET     = 3'd3;
  localparam act_t ACT_CLR_ALL = 3'd4;

  localparam st_t ST_OK      = 2'd0;
  localparam st_t ST_EMPTY   = 2'd1;
  localparam st_t ST_FULL    = 2'd2;
  localparam st_t ST_MISSING = 2'd3;

  // Status of the key scan, handed from the scan unit to the controller.
  typedef struct packed {
    logic done;
    logic hit;
  } scan_stat_t;

  // A key ends at its first zero byte; every byte after it is forced to zero.
  function automatic key_t norm_key(input key_t raw);
    key_t res;
    logic ended;
    res   = raw;
    ended = 1'b0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (ended) begin
        res[i*8 +: 8] = 8'h00;
      end else if (raw[i*8 +: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

>>> design/kct_ram.sv
// ----------------------------------------------------------------------------
// kct_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module kct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/kct_scan.sv
// ----------------------------------------------------------------------------
// kct_scan: key search over the allocated entries
// Issues one key memory read per cycle and compares the returned key in the
// cycle after, stopping at the first match or after the last entry in use.
// ----------------------------------------------------------------------------
module kct_scan #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start_i,
  input  logic [$clog2(TABLE_ENTRIES+1)-1:0]     used_i,
  input  kct_pkg::key_t                          key_i,
  input  kct_pkg::key_t                          rd_data_i,
  output logic [(TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1)-1:0] rd_addr_o,
  output logic [(TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1)-1:0] idx_o,
  output kct_pkg::scan_stat_t                    stat_o
);
  import kct_pkg::*;

  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int USED_W = $clog2(TABLE_ENTRIES + 1);

  logic              busy_r, busy_nxt;
  logic [USED_W-1:0] addr_r, addr_nxt;
  logic              cmp_v_r, cmp_v_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic              issue, hit, done;

  assign issue = busy_r && (addr_r < used_i);
  assign hit   = busy_r && cmp_v_r && (rd_data_i == key_i);
  assign done  = hit || (busy_r && !issue);

  always_comb begin
    busy_nxt    = busy_r;
    addr_nxt    = addr_r;
    cmp_v_nxt   = cmp_v_r;
    cmp_idx_nxt = cmp_idx_r;
    if (start_i) begin
      busy_nxt  = 1'b1;
      addr_nxt  = '0;
      cmp_v_nxt = 1'b0;
    end else if (busy_r) begin
      if (done) begin
        busy_nxt = 1'b0;
      end
      cmp_v_nxt = issue;
      if (issue) begin
        addr_nxt    = addr_r + USED_W'(1);
        cmp_idx_nxt = addr_r[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      cmp_v_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      cmp_v_r <= cmp_v_nxt;
    end
    addr_r    <= addr_nxt;
    cmp_idx_r <= cmp_idx_nxt;
  end

  assign rd_addr_o   = addr_r[IDX_W-1:0];
  assign idx_o       = cmp_idx_r;
  assign stat_o.done = done;
  assign stat_o.hit  = hit;

endmodule

>>> design/keyed_counter_table_top.sv
// ----------------------------------------------------------------------------
// keyed_counter_table_top: table of named saturating counters
// Keys of up to 31 bytes are allocated in order in a key memory, with one
// count per entry in a count memory; each input word performs one action.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Word contents
//   in_      input      in_valid / in_ready   action, four key words, start count
//   out_     output     out_valid / out_ready count value, status
//
// One word is worked on at a time. Clear all, unused actions and empty keys
// go straight to the result; every other word waits on the key scan, which
// reads one stored key per cycle through the single read port of the key
// memory. Reset clears the entry count but not the memories, so no memory
// clearing pass is needed. A held result stalls only the word behind it.
//
module keyed_counter_table_top #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [kct_pkg::ACT_W-1:0] in_action,
  input  logic [63:0]            in_key_word_0,
  input  logic [63:0]            in_key_word_1,
  input  logic [63:0]            in_key_word_2,
  input  logic [55:0]            in_key_word_3,
  input  logic signed [31:0]     in_start_count,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [kct_pkg::CNT_W-1:0] out_count_value,
  output logic [kct_pkg::ST_W-1:0]  out_status
);
  import kct_pkg::*;

  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int USED_W = $clog2(TABLE_ENTRIES + 1);

  // Controller states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  act_t              act_r, act_nxt;
  key_t              key_r, key_nxt;
  cnt_t              start_r, start_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [USED_W-1:0] used_r, used_nxt;
  cnt_t              res_cnt_r, res_cnt_nxt;
  st_t               res_st_r, res_st_nxt;
  logic              out_valid_r, out_valid_nxt;
  cnt_t              out_cnt_r, out_cnt_nxt;
  st_t               out_st_r, out_st_nxt;

  key_t              in_key;
  cnt_t              in_start;

  // Memory ports.
  logic              key_we;
  key_t              key_rdata;
  logic [IDX_W-1:0]  key_raddr;
  logic              cnt_we;
  logic [IDX_W-1:0]  cnt_waddr;
  cnt_t              cnt_wdata;
  cnt_t              cnt_rdata;

  // Scan unit.
  logic              scan_start;
  logic [IDX_W-1:0]  scan_idx;
  scan_stat_t        scan_stat;

  cnt_t              bumped;

  // The key is cleaned up as it is taken in, so stored and searched keys
  // always agree beyond the terminating zero byte. Negative start counts
  // clamp to zero.
  assign in_key   = norm_key({in_key_word_3, in_key_word_2, in_key_word_1, in_key_word_0});
  assign in_start = in_start_count[31] ? '0 : cnt_t'(in_start_count[30:0]);

  assign bumped = (cnt_rdata == COUNT_MAX) ? cnt_rdata : cnt_rdata + cnt_t'(1);

  // New entries are always written at the fill position; updates of an
  // existing entry go to the index found by the scan.
  assign cnt_waddr = (state_r == S_UPD) ? idx_r : used_r[IDX_W-1:0];

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    act_nxt     = act_r;
    key_nxt     = key_r;
    start_nxt   = start_r;
    idx_nxt     = idx_r;
    used_nxt    = used_r;
    res_cnt_nxt = res_cnt_r;
    res_st_nxt  = res_st_r;
    key_we      = 1'b0;
    cnt_we      = 1'b0;
    cnt_wdata   = '0;
    scan_start  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt     = in_action;
          key_nxt     = in_key;
          start_nxt   = in_start;
          res_cnt_nxt = '0;
          res_st_nxt  = ST_OK;
          state_nxt   = S_FIN;
          case (in_action) inside
            ACT_BUMP, ACT_QUERY, ACT_CLEAR, ACT_SET: begin
              if (in_key[7:0] == 8'h00) begin
                res_st_nxt = ST_EMPTY;
              end else begin
                scan_start = 1'b1;
                state_nxt  = S_SCAN;
              end
            end
            ACT_CLR_ALL: begin
              used_nxt = '0;
            end
            default: begin
              // Unused action codes leave the table alone.
            end
          endcase
        end
      end

      S_SCAN: begin
        if (scan_stat.done) begin
          if (scan_stat.hit) begin
            idx_nxt   = scan_idx;
            state_nxt = S_UPD;
          end else begin
            state_nxt = S_FIN;
            if (act_r == ACT_BUMP || act_r == ACT_SET) begin
              if (used_r == USED_W'(TABLE_ENTRIES)) begin
                res_cnt_nxt = '0;
                res_st_nxt  = ST_FULL;
              end else begin
                cnt_wdata   = (act_r == ACT_BUMP) ? cnt_t'(1) : start_r;
                key_we      = 1'b1;
                cnt_we      = 1'b1;
                used_nxt    = used_r + USED_W'(1);
                res_cnt_nxt = cnt_wdata;
                res_st_nxt  = ST_OK;
              end
            end else begin
              res_cnt_nxt = '0;
              res_st_nxt  = ST_MISSING;
            end
          end
        end
      end

      S_UPD: begin
        // The count of the matching entry arrives from the count memory now.
        state_nxt  = S_FIN;
        res_st_nxt = ST_OK;
        case (act_r)
          ACT_BUMP: begin
            cnt_we      = 1'b1;
            cnt_wdata   = bumped;
            res_cnt_nxt = bumped;
          end
          ACT_QUERY: begin
            res_cnt_nxt = cnt_rdata;
          end
          ACT_CLEAR: begin
            cnt_we      = 1'b1;
            cnt_wdata   = '0;
            res_cnt_nxt = '0;
          end
          default: begin
            cnt_we      = 1'b1;
            cnt_wdata   = start_r;
            res_cnt_nxt = start_r;
          end
        endcase
      end

      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: loaded from the finished result as soon as it is free.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_cnt_nxt   = out_cnt_r;
    out_st_nxt    = out_st_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
      out_valid_nxt = 1'b1;
      out_cnt_nxt   = res_cnt_r;
      out_st_nxt    = res_st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r     <= act_nxt;
    key_r     <= key_nxt;
    start_r   <= start_nxt;
    idx_r     <= idx_nxt;
    res_cnt_r <= res_cnt_nxt;
    res_st_r  <= res_st_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_count_value = out_cnt_r;
  assign out_status      = out_st_r;

  kct_scan #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_i   (scan_start),
    .used_i    (used_r),
    .key_i     (key_r),
    .rd_data_i (key_rdata),
    .rd_addr_o (key_raddr),
    .idx_o     (scan_idx),
    .stat_o    (scan_stat)
  );

  // Key memory: one whole 31-byte key per entry.
  kct_ram #(
    .WIDTH(KEY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (used_r[IDX_W-1:0]),
    .wdata (key_r),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  // Count memory: read at the index the scan is reporting, so the data is
  // there in the cycle after a match.
  kct_ram #(
    .WIDTH(CNT_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (scan_idx),
    .rdata (cnt_rdata)
  );

endmodule

>>> dv/tb_keyed_counter_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_counter_table_top: self-checking bench for the keyed counter table
// Drives action and key words through the valid/ready input channel. A
// scoreboard class keeps its own copy of the table and predicts each result.
// A directed opening covers the special cases. A random phase follows: names
// from a small pool, so that keys hit, miss and fill the table.
// ----------------------------------------------------------------------------
module tb_keyed_counter_table_top;
  import kct_pkg::*;

  localparam int TABLE_ENTRIES = 16;
  localparam int RANDOM_WORDS  = 830;
  localparam int CALM_WORDS    = 120;  // final stretch with no idling on either side
  localparam int POOL_SIZE     = 24;   // more names than entries, so the table can fill

  // The block ignores action codes above clear-all; they still return a word.
  localparam act_t ACT_SPARE_FIRST = 3'd5;
  localparam act_t ACT_SPARE_LAST  = 3'd7;

  typedef struct {
    cnt_t count;
    st_t  status;
  } count_reply_t;

  // Scoreboard: mirrors the table, predicts the reply to each accepted word
  // and compares the replies from the block in order.
  class table_scoreboard;
    key_t         stored_keys [TABLE_ENTRIES];
    cnt_t         stored_counts [TABLE_ENTRIES];
    int unsigned  entries_used;
    count_reply_t awaited_replies [$];
    int           mismatches;

    function new();
      entries_used = 0;
      mismatches   = 0;
    endfunction

    // A name ends at its first zero byte; whatever follows it does not count.
    function key_t trim_name(key_t raw);
      key_t k;
      bit   ended;
      k     = raw;
      ended = 1'b0;
      for (int b = 0; b < KEY_BYTES; b++) begin
        if (ended) begin
          k[b*8 +: 8] = 8'h00;
        end else if (k[b*8 +: 8] == 8'h00) begin
          ended = 1'b1;
        end
      end
      return k;
    endfunction

    function void note_word(act_t act, key_t raw, logic signed [31:0] start);
      key_t         k;
      int           hit;
      cnt_t         fresh;
      count_reply_t r;
      k        = trim_name(raw);
      hit      = -1;
      r.count  = '0;
      r.status = ST_OK;
      for (int i = 0; i < entries_used; i++) begin
        if (hit < 0 && stored_keys[i] == k) hit = i;
      end
      fresh = start[31] ? cnt_t'(0) : cnt_t'(start[30:0]);
      if (act == ACT_CLR_ALL) begin
        entries_used = 0;
      end else if (act <= ACT_SET) begin
        if (k[7:0] == 8'h00) begin
          r.status = ST_EMPTY;
        end else begin
          case (act)
            ACT_BUMP: begin
              if (hit >= 0) begin
                if (stored_counts[hit] != COUNT_MAX) stored_counts[hit]++;
                r.count = stored_counts[hit];
              end else if (entries_used < TABLE_ENTRIES) begin
                stored_keys[entries_used]   = k;
                stored_counts[entries_used] = cnt_t'(1);
                entries_used++;
                r.count = cnt_t'(1);
              end else begin
                r.status = ST_FULL;
              end
            end
            ACT_QUERY: begin
              if (hit >= 0) r.count = stored_counts[hit];
              else r.status = ST_MISSING;
            end
            ACT_CLEAR: begin
              if (hit >= 0) stored_counts[hit] = '0;
              else r.status = ST_MISSING;
            end
            default: begin
              if (hit >= 0) begin
                stored_counts[hit] = fresh;
                r.count = fresh;
              end else if (entries_used < TABLE_ENTRIES) begin
                stored_keys[entries_used]   = k;
                stored_counts[entries_used] = fresh;
                entries_used++;
                r.count = fresh;
              end else begin
                r.status = ST_FULL;
              end
            end
          endcase
        end
      end
      awaited_replies.push_back(r);
    endfunction

    function void check_result(cnt_t count, st_t status);
      count_reply_t r;
      if (awaited_replies.size() == 0) begin
        $display("%0t: unexpected reply, count %0d status %0d", $time, count, status);
        mismatches++;
      end else begin
        r = awaited_replies.pop_front();
        if (count !== r.count) begin
          $display("%0t: count mismatch, expected %0d actual %0d", $time, r.count, count);
          mismatches++;
        end
        if (status !== r.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d", $time, r.status, status);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return awaited_replies.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  act_t                 in_action = ACT_QUERY;
  logic [63:0]          in_key_word_0 = '0;
  logic [63:0]          in_key_word_1 = '0;
  logic [63:0]          in_key_word_2 = '0;
  logic [55:0]          in_key_word_3 = '0;
  logic signed [31:0]   in_start_count = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  cnt_t                 out_count_value;
  st_t                  out_status;

  table_scoreboard      sb = new();
  bit                   calm_tail = 1'b0;
  key_t                 name_pool [POOL_SIZE];

  keyed_counter_table_top #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_key_word_0  (in_key_word_0),
    .in_key_word_1  (in_key_word_1),
    .in_key_word_2  (in_key_word_2),
    .in_key_word_3  (in_key_word_3),
    .in_start_count (in_start_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_count_value(out_count_value),
    .out_status     (out_status)
  );

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  // Every reply taken by the sink is handed to the scoreboard. Sampling at the
  // edge sees the values from before the edge, as the block does.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_count_value, out_status);
  end

  // Back-pressure on the reply channel: long and short runs of readiness,
  // broken by stalls, and none in the calm tail.
  initial begin : sink_pacing
    int run;
    forever begin
      run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      if (!calm_tail && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end
  end

  // Builds a key from text, first character in the low byte.
  function automatic key_t text_key(string s);
    key_t k;
    k = '0;
    for (int i = 0; i < s.len() && i < KEY_BYTES; i++) k[i*8 +: 8] = s[i];
    return k;
  endfunction

  // A fresh name of one to thirty-one non-zero bytes; full length is favoured.
  function automatic key_t random_name();
    key_t k;
    int   len;
    k   = '0;
    len = ($urandom_range(0, 9) < 3) ? KEY_BYTES : $urandom_range(1, KEY_BYTES);
    for (int b = 0; b < len; b++) k[b*8 +: 8] = 8'($urandom_range(1, 255));
    return k;
  endfunction

  // Fills the bytes after the terminating zero with noise. The block must
  // still treat the result as the same name.
  function automatic key_t noisy_tail(key_t k);
    key_t res;
    bit   ended;
    res   = k;
    ended = 1'b0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (ended) res[b*8 +: 8] = 8'($urandom_range(0, 255));
      else if (res[b*8 +: 8] == 8'h00) ended = 1'b1;
    end
    return res;
  endfunction

  function automatic key_t random_bytes();
    key_t k;
    for (int b = 0; b < KEY_BYTES; b++) k[b*8 +: 8] = 8'($urandom_range(0, 255));
    return k;
  endfunction

  function automatic int pick_gap();
    if (calm_tail) return 0;
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
  endfunction

  // Presents one word and holds it until it is taken. Valid is only dropped
  // when a gap follows, so that a back-to-back word keeps it high throughout.
  task automatic send_word(act_t act, key_t k, logic signed [31:0] start);
    int gap;
    gap = pick_gap();
    in_valid       <= 1'b1;
    in_action      <= act;
    in_key_word_0  <= k[63:0];
    in_key_word_1  <= k[127:64];
    in_key_word_2  <= k[191:128];
    in_key_word_3  <= k[247:192];
    in_start_count <= start;
    do @(posedge clk); while (!in_ready);
    sb.note_word(act, k, start);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops sending until every reply still owed has been taken.
  task automatic drain_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    key_t               k;
    key_t               ones;
    act_t               act;
    logic signed [31:0] start;
    int                 sel;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening: creation, hits and misses, empty keys, clamping,
    // saturation, trailing noise after the terminator, spare codes, clear-all.
    ones = '1;
    send_word(ACT_BUMP,  text_key("alpha"), 32'sd0);
    send_word(ACT_BUMP,  text_key("alpha"), 32'sd0);
    send_word(ACT_QUERY, text_key("alpha"), 32'sd0);
    send_word(ACT_QUERY, text_key("beta"),  32'sd0);
    send_word(ACT_CLEAR, text_key("beta"),  32'sd0);
    send_word(ACT_BUMP,  '0, 32'sd0);
    k = ones;
    k[7:0] = 8'h00;
    send_word(ACT_QUERY, k, 32'sd0);
    send_word(ACT_SET,   k, 32'sd77);
    send_word(ACT_SET,   text_key("gamma"), -32'sd5);
    send_word(ACT_SET,   text_key("gamma"), 32'sh7FFF_FFFF);
    send_word(ACT_BUMP,  text_key("gamma"), 32'sd0);
    send_word(ACT_SET,   text_key("alpha"), 32'sh8000_0000);
    send_word(ACT_CLEAR, text_key("gamma"), 32'sd0);
    send_word(ACT_QUERY, text_key("gamma"), 32'sd0);
    send_word(ACT_BUMP,  noisy_tail(text_key("alpha")), 32'sd0);
    send_word(ACT_BUMP,  ones, 32'sd0);
    send_word(ACT_QUERY, ones, -32'sd1);
    k = '0;
    for (int b = 0; b < KEY_BYTES; b++) k[b*8 +: 8] = 8'h80;
    send_word(ACT_SET,   k, 32'sh7FFF_FFFF);
    for (int c = ACT_SPARE_FIRST; c <= ACT_SPARE_LAST; c++) begin
      send_word(act_t'(c), random_bytes(), $urandom);
    end
    send_word(ACT_CLR_ALL, random_bytes(), 32'sd0);
    send_word(ACT_QUERY, text_key("alpha"), 32'sd0);
    send_word(ACT_BUMP,  text_key("delta"), 32'sd0);
    drain_replies();

    // Random phase: mostly names from the pool, so that bumps and sets land
    // on live entries and the table fills; the rest is empty keys and noise.
    for (int i = 0; i < POOL_SIZE; i++) name_pool[i] = random_name();
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS - CALM_WORDS) calm_tail = 1'b1;
      if (n > 0 && n % 200 == 0 && !calm_tail) drain_replies();

      sel = $urandom_range(0, 99);
      if (sel < 2) act = ACT_CLR_ALL;
      else if (sel < 4) act = act_t'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
      else if (sel < 49) act = ACT_BUMP;
      else if (sel < 69) act = ACT_QUERY;
      else if (sel < 79) act = ACT_CLEAR;
      else act = ACT_SET;

      sel = $urandom_range(0, 99);
      if (sel < 85) begin
        k = name_pool[$urandom_range(0, POOL_SIZE - 1)];
        if ($urandom_range(0, 9) < 3) k = noisy_tail(k);
      end else if (sel < 92) begin
        k = random_bytes();
        k[7:0] = 8'h00;
      end else begin
        k = random_bytes();
      end

      // Counts near the top make saturation reachable by a few bumps.
      sel = $urandom_range(0, 99);
      if (sel < 50) start = $urandom;
      else if (sel < 70) start = $urandom_range(0, 100);
      else if (sel < 85) start = 32'sh7FFF_FFFF - $urandom_range(0, 3);
      else start = -$signed({1'b0, 31'($urandom)}) - 1;

      send_word(act, k, start);
    end

    drain_replies();
    repeat (TABLE_ENTRIES + 8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("keyed_counter_table_top test passed");
    end else begin
      $display("keyed_counter_table_top test failed");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("keyed_counter_table_top test failed");
    $finish;
  end

endmodule

>>> filelist.f
design/kct_pkg.sv
design/kct_ram.sv
design/kct_scan.sv
design/keyed_counter_table_top.sv
dv/tb_keyed_counter_table_top.sv
